// ----- rtl/usb_midi_packet_to_led_commands_unit_macros.svh -----
// ============================================================================
// Assertion macros for the USB-MIDI to LED command unit
// Shared property templates, clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef USB_MIDI_PACKET_TO_LED_COMMANDS_UNIT_MACROS_SVH
`define USB_MIDI_PACKET_TO_LED_COMMANDS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USBLED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define USBLED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/usbled_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// usbled_pkg
// Types and constant tables shared by the USB-MIDI to LED command unit.
// ============================================================================
package usbled_pkg;

    typedef enum logic [0:0] {
        CMD_LED       = 1'b0,
        CMD_CHALLENGE = 1'b1
    } cmd_kind_t;

    typedef enum logic [0:0] {
        RES_LED      = 1'b0,
        RES_RESPONSE = 1'b1
    } result_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] x;
        logic [2:0] y;
        logic [6:0] colour;
        logic [3:0] lighting;
    } cmd_t;

    typedef struct packed {
        logic [6:0] r;
        logic [6:0] g;
        logic [6:0] b;
    } rgb_t;

    // Code index numbers.
    localparam logic [3:0] CIN_SX_CONT = 4'd4;
    localparam logic [3:0] CIN_SX_END1 = 4'd5;
    localparam logic [3:0] CIN_SX_END2 = 4'd6;
    localparam logic [3:0] CIN_SX_END3 = 4'd7;
    localparam logic [3:0] CIN_NOTE_OFF = 4'd8;
    localparam logic [3:0] CIN_NOTE_ON = 4'd9;
    localparam logic [3:0] CIN_CTRL = 4'd11;

    localparam logic [2:0] LAYOUT_DEFAULT = 3'd0;
    localparam logic [2:0] LAYOUT_DRUM = 3'd1;

    localparam logic [7:0] SX_SET_LAYOUT = 8'h22;
    localparam logic [7:0] SX_CHALLENGE = 8'h40;
    localparam int SX_MIN_LEN = 8;
    localparam int SX_HEAD_LEN = 8;
    localparam int SX_ID_LEN = 6;

    localparam int CMD_FIFO_DEPTH = 4;

    localparam int REPLY_LEN = 10;
    localparam logic [3:0] REPLY_LAST = 4'(REPLY_LEN - 1);

    localparam logic [7:0] REPLY_BYTES [REPLY_LEN] = '{
        8'hF0, 8'h00, 8'h20, 8'h29, 8'h02, 8'h18, 8'h40, 8'h00, 8'h00, 8'hF7
    };

    localparam logic [7:0] SX_ID [SX_ID_LEN] = '{
        8'hF0, 8'h00, 8'h20, 8'h29, 8'h02, 8'h18
    };

    // Controller number for each row of the control column.
    localparam logic [7:0] CTRL_COLUMN [8] = '{
        8'd110, 8'd111, 8'd109, 8'd108, 8'd104, 8'd106, 8'd107, 8'd105
    };

    localparam rgb_t PALETTE [128] = '{
        '{7'd0,7'd0,7'd0},    '{7'd8,7'd8,7'd8},    '{7'd32,7'd32,7'd32}, '{7'd64,7'd64,7'd64},
        '{7'd64,7'd20,7'd18}, '{7'd64,7'd3,7'd0},   '{7'd23,7'd1,7'd0},   '{7'd7,7'd0,7'd0},
        '{7'd64,7'd48,7'd25}, '{7'd64,7'd22,7'd0},  '{7'd23,7'd8,7'd0},   '{7'd10,7'd7,7'd0},
        '{7'd64,7'd64,7'd9},  '{7'd64,7'd64,7'd0},  '{7'd23,7'd23,7'd0},  '{7'd6,7'd6,7'd0},
        '{7'd33,7'd64,7'd11}, '{7'd17,7'd64,7'd0},  '{7'd6,7'd23,7'd0},   '{7'd5,7'd11,7'd0},
        '{7'd14,7'd64,7'd11}, '{7'd0,7'd64,7'd0},   '{7'd0,7'd23,7'd0},   '{7'd0,7'd7,7'd0},
        '{7'd13,7'd64,7'd18}, '{7'd0,7'd64,7'd0},   '{7'd0,7'd23,7'd0},   '{7'd0,7'd7,7'd0},
        '{7'd13,7'd64,7'd32}, '{7'd0,7'd64,7'd15},  '{7'd0,7'd23,7'd6},   '{7'd0,7'd8,7'd4},
        '{7'd12,7'd64,7'd45}, '{7'd0,7'd64,7'd37},  '{7'd0,7'd23,7'd13},  '{7'd0,7'd7,7'd4},
        '{7'd15,7'd48,7'd64}, '{7'd0,7'd42,7'd64},  '{7'd0,7'd17,7'd21},  '{7'd0,7'd5,7'd7},
        '{7'd17,7'd34,7'd64}, '{7'd0,7'd21,7'd64},  '{7'd0,7'd7,7'd23},   '{7'd0,7'd2,7'd7},
        '{7'd18,7'd18,7'd64}, '{7'd0,7'd0,7'd64},   '{7'd0,7'd0,7'd23},   '{7'd0,7'd0,7'd7},
        '{7'd33,7'd18,7'd64}, '{7'd21,7'd0,7'd64},  '{7'd6,7'd0,7'd26},   '{7'd3,7'd0,7'd13},
        '{7'd64,7'd19,7'd64}, '{7'd64,7'd0,7'd64},  '{7'd23,7'd0,7'd23},  '{7'd7,7'd0,7'd7},
        '{7'd64,7'd20,7'd34}, '{7'd64,7'd2,7'd21},  '{7'd23,7'd1,7'd7},   '{7'd9,7'd0,7'd5},
        '{7'd64,7'd7,7'd0},   '{7'd39,7'd14,7'd0},  '{7'd31,7'd21,7'd0},  '{7'd16,7'd26,7'd0},
        '{7'd0,7'd15,7'd0},   '{7'd0,7'd22,7'd13},  '{7'd0,7'd21,7'd32},  '{7'd0,7'd0,7'd64},
        '{7'd0,7'd18,7'd20},  '{7'd7,7'd0,7'd53},   '{7'd32,7'd32,7'd32}, '{7'd9,7'd9,7'd9},
        '{7'd64,7'd3,7'd0},   '{7'd47,7'd64,7'd0},  '{7'd43,7'd60,7'd0},  '{7'd22,7'd64,7'd0},
        '{7'd0,7'd35,7'd0},   '{7'd0,7'd64,7'd31},  '{7'd0,7'd42,7'd64},  '{7'd0,7'd7,7'd64},
        '{7'd14,7'd0,7'd64},  '{7'd30,7'd0,7'd64},  '{7'd46,7'd6,7'd32},  '{7'd17,7'd9,7'd0},
        '{7'd64,7'd19,7'd0},  '{7'd33,7'd57,7'd0},  '{7'd26,7'd64,7'd0},  '{7'd0,7'd64,7'd0},
        '{7'd0,7'd64,7'd0},   '{7'd18,7'd64,7'd25}, '{7'd0,7'd64,7'd51},  '{7'd21,7'd34,7'd64},
        '{7'd10,7'd20,7'd51}, '{7'd33,7'd31,7'd60}, '{7'd53,7'd4,7'd64},  '{7'd64,7'd2,7'd23},
        '{7'd64,7'd32,7'd0},  '{7'd47,7'd45,7'd0},  '{7'd35,7'd64,7'd0},  '{7'd33,7'd24,7'd0},
        '{7'd14,7'd11,7'd0},  '{7'd4,7'd20,7'd2},   '{7'd0,7'd21,7'd14},  '{7'd5,7'd5,7'd11},
        '{7'd5,7'd8,7'd23},   '{7'd27,7'd16,7'd6},  '{7'd44,7'd2,7'd0},   '{7'd64,7'd21,7'd14},
        '{7'd56,7'd27,7'd0},  '{7'd64,7'd64,7'd0},  '{7'd39,7'd57,7'd0},  '{7'd24,7'd46,7'd0},
        '{7'd7,7'd7,7'd13},   '{7'd56,7'd64,7'd21}, '{7'd30,7'd64,7'd47}, '{7'd38,7'd38,7'd64},
        '{7'd35,7'd25,7'd64}, '{7'd17,7'd17,7'd17}, '{7'd30,7'd30,7'd30}, '{7'd56,7'd64,7'd64},
        '{7'd42,7'd2,7'd0},   '{7'd14,7'd0,7'd0},   '{7'd0,7'd53,7'd0},   '{7'd0,7'd17,7'd0},
        '{7'd47,7'd45,7'd0},  '{7'd16,7'd13,7'd0},  '{7'd46,7'd24,7'd0},  '{7'd19,7'd6,7'd0}
    };

endpackage

// ----- rtl/usbled_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// usbled_front
// Accepts USB-MIDI packets, tracks layout and sysex assembly, and turns each
// packet into at most one LED or challenge command for the back end.
// ============================================================================
module usbled_front #(
    parameter int SYSEX_MAX = 64,
    parameter int LAYOUT_MAX = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         header,
    input  logic [7:0]         byte0,
    input  logic [7:0]         byte1,
    input  logic [7:0]         byte2,
    input  logic               cmd_full,
    output logic               cmd_push,
    output usbled_pkg::cmd_t   cmd_data
);
    import usbled_pkg::*;

    localparam logic [6:0] SX_DROP_AT = 7'(SYSEX_MAX - 3);
    localparam logic [7:0] LAYOUT_LIMIT = 8'(LAYOUT_MAX);

    logic [2:0] layout_reg, layout_next;
    logic [6:0] sx_count_reg, sx_count_next;
    logic [7:0] sx_head_reg [SX_HEAD_LEN];
    logic [7:0] sx_head_new [SX_HEAD_LEN];

    logic       accept;
    logic [3:0] cin;
    logic [3:0] chan;
    logic       is_sx;
    logic       sx_drop;
    logic [1:0] sx_nbytes;
    logic [6:0] sx_sum;
    logic [7:0] sx_bytes [3];
    logic       sx_end;
    logic       sx_match;
    logic       sx_write;
    logic       challenge;

    logic       is_note;
    logic [7:0] vel;
    logic       note_ok;
    logic [3:0] note_x;
    logic [2:0] note_y;
    logic [7:0] drum_d;
    logic [14:0] tens_prod;
    logic [3:0] tens;
    logic [3:0] ones;

    logic       cc_ok;
    logic [2:0] cc_y;
    logic       cc_hit;

    assign in_ready = !cmd_full;
    assign accept = in_valid && in_ready;
    assign cin = header[3:0];
    assign chan = byte0[3:0];

    // ---------------- sysex assembly ----------------
    assign sx_bytes[0] = byte0;
    assign sx_bytes[1] = byte1;
    assign sx_bytes[2] = byte2;

    always_comb
    begin
        is_sx = (cin == CIN_SX_CONT) || (cin == CIN_SX_END1) ||
                (cin == CIN_SX_END2) || (cin == CIN_SX_END3);
        case (cin)
            CIN_SX_END1: sx_nbytes = 2'd1;
            CIN_SX_END2: sx_nbytes = 2'd2;
            default:     sx_nbytes = 2'd3;
        endcase
        sx_drop = sx_count_reg >= SX_DROP_AT;
        sx_sum = sx_count_reg + 7'(sx_nbytes);
        sx_write = accept && is_sx && !sx_drop;
        sx_end = is_sx && !sx_drop && (cin != CIN_SX_CONT);
    end

    always_comb
    begin
        for (int i = 0; i < SX_HEAD_LEN; i++) begin
            sx_head_new[i] = sx_head_reg[i];
            for (int j = 0; j < 3; j++) begin
                if ((2'(j) < sx_nbytes) && (sx_count_reg + 7'(j) == 7'(i)))
                    sx_head_new[i] = sx_bytes[j];
            end
        end
    end

    always_comb
    begin
        sx_match = sx_sum >= 7'(SX_MIN_LEN);
        for (int i = 0; i < SX_ID_LEN; i++) begin
            if (sx_head_new[i] != SX_ID[i])
                sx_match = 1'b0;
        end
        challenge = sx_end && sx_match && (sx_head_new[6] == SX_CHALLENGE);

        layout_next = layout_reg;
        if (accept && sx_end && sx_match && (sx_head_new[6] == SX_SET_LAYOUT) &&
            (sx_head_new[7] <= LAYOUT_LIMIT))
            layout_next = sx_head_new[7][2:0];

        sx_count_next = sx_count_reg;
        if (accept && is_sx) begin
            if (sx_drop || (cin != CIN_SX_CONT))
                sx_count_next = '0;
            else
                sx_count_next = sx_sum;
        end
    end

    // ---------------- note mapping ----------------
    // Tens digit by reciprocal multiply; exact for every 7-bit value of byte1[6:0].
    assign tens_prod = 15'(byte1[6:0]) * 15'd205;
    assign tens = tens_prod[14:11];
    assign ones = 4'(byte1[6:0] - 7'(tens) * 7'd10);

    always_comb
    begin
        is_note = (cin == CIN_NOTE_ON) || (cin == CIN_NOTE_OFF);
        vel = (cin == CIN_NOTE_ON) ? byte2 : 8'd0;
        note_ok = 1'b0;
        note_x = '0;
        note_y = '0;
        drum_d = '0;
        if (layout_reg == LAYOUT_DRUM) begin
            if (byte1 >= 8'd36 && byte1 <= 8'd67) begin
                drum_d = byte1 - 8'd36;
                note_x = {2'b00, byte1[1:0]};
                note_y = drum_d[4:2];
                note_ok = 1'b1;
            end else if (byte1 >= 8'd68 && byte1 <= 8'd99) begin
                drum_d = byte1 - 8'd68;
                note_x = {2'b01, byte1[1:0]};
                note_y = drum_d[4:2];
                note_ok = 1'b1;
            end else if (byte1 >= 8'd100 && byte1 <= 8'd107) begin
                drum_d = 8'd107 - byte1;
                note_x = 4'd8;
                note_y = drum_d[2:0];
                note_ok = 1'b1;
            end
        end else if (byte1 >= 8'd11 && byte1 <= 8'd89 && ones != 4'd0) begin
            note_x = ones - 4'd1;
            note_y = 3'(tens - 4'd1);
            note_ok = 1'b1;
        end
        note_ok = note_ok && is_note && !vel[7];
    end

    // ---------------- control column ----------------
    always_comb
    begin
        cc_hit = 1'b0;
        cc_y = '0;
        for (int i = 0; i < 8; i++) begin
            if (CTRL_COLUMN[i] == byte1) begin
                cc_hit = 1'b1;
                cc_y = 3'(i);
            end
        end
        cc_ok = (cin == CIN_CTRL) && cc_hit && !byte2[7];
    end

    // ---------------- command out ----------------
    always_comb
    begin
        cmd_data.kind = CMD_LED;
        cmd_data.x = note_x;
        cmd_data.y = note_y;
        cmd_data.colour = vel[6:0];
        cmd_data.lighting = (chan <= 4'd2) ? chan : 4'd0;
        if (cc_ok) begin
            cmd_data.x = 4'd9;
            cmd_data.y = cc_y;
            cmd_data.colour = byte2[6:0];
            cmd_data.lighting = chan;
        end else if (challenge) begin
            cmd_data.kind = CMD_CHALLENGE;
        end
        cmd_push = accept && (note_ok || cc_ok || challenge);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            layout_reg <= LAYOUT_DEFAULT;
            sx_count_reg <= '0;
        end else begin
            layout_reg <= layout_next;
            sx_count_reg <= sx_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sx_write) begin
            for (int i = 0; i < SX_HEAD_LEN; i++)
                sx_head_reg[i] <= sx_head_new[i];
        end
    end

endmodule

// ----- rtl/usbled_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ============================================================================
// usbled_cmd_fifo
// Short command queue between the packet decoder and the result generator.
// ============================================================================
module usbled_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  usbled_pkg::cmd_t   push_data,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output usbled_pkg::cmd_t   head_data
);
    import usbled_pkg::*;

    localparam int PtrW = $clog2(CMD_FIFO_DEPTH);

    cmd_t            entries_reg [CMD_FIFO_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full = count_reg == (PtrW + 1)'(CMD_FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/usbled_back.sv -----
`timescale 1ns / 1ps
`include "usb_midi_packet_to_led_commands_unit_macros.svh"
// ============================================================================
// usbled_back
// Executes queued commands: one LED write with palette colour, or the
// ten-byte challenge response, into a registered output stage.
// ============================================================================
module usbled_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  usbled_pkg::cmd_t   cmd_data,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic [3:0]         led_x,
    output logic [2:0]         led_y,
    output logic [6:0]         red,
    output logic [6:0]         green,
    output logic [6:0]         blue,
    output logic [3:0]         lighting,
    output logic [7:0]         response_byte,
    output logic               last
);
    import usbled_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic [3:0]   idx_reg, idx_next;
    result_kind_t kind_reg, kind_next;
    logic [3:0]   x_reg, x_next;
    logic [2:0]   y_reg, y_next;
    rgb_t         rgb_reg, rgb_next;
    logic [3:0]   light_reg, light_next;
    logic [7:0]   resp_reg, resp_next;
    logic         last_reg, last_next;
    logic         load;

    // The output register takes a new result whenever it is empty or being drained.
    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next = idx_reg;
        kind_next = kind_reg;
        x_next = x_reg;
        y_next = y_reg;
        rgb_next = rgb_reg;
        light_next = light_reg;
        resp_next = resp_reg;
        last_next = last_reg;
        cmd_pop = 1'b0;
        if (load) begin
            out_valid_next = cmd_valid;
            if (cmd_valid) begin
                if (cmd_data.kind == CMD_LED) begin
                    kind_next = RES_LED;
                    x_next = cmd_data.x;
                    y_next = cmd_data.y;
                    rgb_next = PALETTE[cmd_data.colour];
                    light_next = cmd_data.lighting;
                    resp_next = '0;
                    last_next = 1'b1;
                    cmd_pop = 1'b1;
                end else begin
                    kind_next = RES_RESPONSE;
                    x_next = '0;
                    y_next = '0;
                    rgb_next = '0;
                    light_next = '0;
                    resp_next = REPLY_BYTES[idx_reg];
                    last_next = idx_reg == REPLY_LAST;
                    if (idx_reg == REPLY_LAST) begin
                        idx_next = '0;
                        cmd_pop = 1'b1;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        x_reg <= x_next;
        y_reg <= y_next;
        rgb_reg <= rgb_next;
        light_reg <= light_next;
        resp_reg <= resp_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign result_kind = kind_reg;
    assign led_x = x_reg;
    assign led_y = y_reg;
    assign red = rgb_reg.r;
    assign green = rgb_reg.g;
    assign blue = rgb_reg.b;
    assign lighting = light_reg;
    assign response_byte = resp_reg;
    assign last = last_reg;

    `USBLED_ASSERT_NOW(a_burst_head, idx_reg != 4'd0,
        cmd_valid && cmd_data.kind == CMD_CHALLENGE, "response burst lost its command")
    `USBLED_ASSERT_NOW(a_idx_range, 1'b1, idx_reg <= REPLY_LAST,
        "response index out of range")
    `USBLED_ASSERT_NEXT(a_burst_gapless,
        out_valid_reg && kind_reg == RES_RESPONSE && !last_reg && out_ready,
        out_valid_reg && kind_reg == RES_RESPONSE, "gap inside response burst")

endmodule

// ----- rtl/usb_midi_packet_to_led_commands_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// usb_midi_packet_to_led_commands_unit
// Decodes USB-MIDI event packets into grid LED writes and sysex replies.
// ============================================================================
// Input channel (in_valid/in_ready): one 4-byte USB-MIDI event packet per
// request. Output channel (out_valid/out_ready): one result per request,
// either an LED write (result_kind 0) or one challenge response byte
// (result_kind 1); last marks the final result of a packet.
// Packets that cause no result (unmapped notes, partial sysex, unknown code
// index) are absorbed without output.
// With the queue empty, an accepted packet's command is written to the queue
// and then loaded from its head into the output register. Throughput: one
// packet per cycle while the queue is not full; an LED write is one result,
// a challenge ten response bytes, one per cycle while out_ready is high.
// A four-entry command queue sits between the decoder and the output stage;
// in_ready drops only while that queue is full, so a stalled receiver
// back-pressures the input once four commands wait behind the one held in
// the output register.
// Reset selects the session layout and clears sysex assembly; the queue
// and output register come up empty.
// ============================================================================
module usb_midi_packet_to_led_commands_unit #(
    parameter int SYSEX_MAX = 64,
    parameter int LAYOUT_MAX = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] header,
    input  logic [7:0] byte0,
    input  logic [7:0] byte1,
    input  logic [7:0] byte2,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [3:0] led_x,
    output logic [2:0] led_y,
    output logic [6:0] red,
    output logic [6:0] green,
    output logic [6:0] blue,
    output logic [3:0] lighting,
    output logic [7:0] response_byte,
    output logic       last
);
    import usbled_pkg::*;

    logic cmd_full;
    logic cmd_push;
    cmd_t cmd_push_data;
    logic cmd_pop;
    logic cmd_valid;
    cmd_t cmd_head;

    usbled_front #(
        .SYSEX_MAX  (SYSEX_MAX),
        .LAYOUT_MAX (LAYOUT_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .header   (header),
        .byte0    (byte0),
        .byte1    (byte1),
        .byte2    (byte2),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_push_data)
    );

    usbled_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (cmd_push_data),
        .pop        (cmd_pop),
        .full       (cmd_full),
        .head_valid (cmd_valid),
        .head_data  (cmd_head)
    );

    usbled_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_data      (cmd_head),
        .cmd_pop       (cmd_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .led_x         (led_x),
        .led_y         (led_y),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .lighting      (lighting),
        .response_byte (response_byte),
        .last          (last)
    );

endmodule

// ----- bench/usb_midi_packet_to_led_commands_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// usb_midi_packet_to_led_commands_unit_tb
// Self-checking bench for the USB-MIDI packet decoder. Directed tests cover
// the note maps of both layouts, the control column, every code index, the
// layout and challenge sysex messages and their corner cases; random traffic
// follows. A behavioral decoder predicts every LED write and reply byte, and
// a monitor compares each output request against the oldest prediction.
// ============================================================================
module usb_midi_packet_to_led_commands_unit_tb;
    import usbled_pkg::*;

    localparam int SYSEX_MAX = 64;
    localparam int LAYOUT_MAX = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PACKETS = 12;
    localparam logic [7:0] SX_END = 8'hF7;

    localparam logic [7:0] maker_id [6] = '{8'hF0, 8'h00, 8'h20, 8'h29, 8'h02, 8'h18};
    localparam logic [7:0] reply_lut [10] = '{
        8'hF0, 8'h00, 8'h20, 8'h29, 8'h02, 8'h18, 8'h40, 8'h00, 8'h00, 8'hF7
    };
    localparam logic [7:0] ctrl_rows [8] = '{110, 111, 109, 108, 104, 106, 107, 105};

    localparam logic [6:0] color_lut [128][3] = '{
        '{0,0,0},'{8,8,8},'{32,32,32},'{64,64,64},'{64,20,18},'{64,3,0},'{23,1,0},'{7,0,0},
        '{64,48,25},'{64,22,0},'{23,8,0},'{10,7,0},'{64,64,9},'{64,64,0},'{23,23,0},'{6,6,0},
        '{33,64,11},'{17,64,0},'{6,23,0},'{5,11,0},'{14,64,11},'{0,64,0},'{0,23,0},'{0,7,0},
        '{13,64,18},'{0,64,0},'{0,23,0},'{0,7,0},'{13,64,32},'{0,64,15},'{0,23,6},'{0,8,4},
        '{12,64,45},'{0,64,37},'{0,23,13},'{0,7,4},'{15,48,64},'{0,42,64},'{0,17,21},
        '{0,5,7},
        '{17,34,64},'{0,21,64},'{0,7,23},'{0,2,7},'{18,18,64},'{0,0,64},'{0,0,23},'{0,0,7},
        '{33,18,64},'{21,0,64},'{6,0,26},'{3,0,13},'{64,19,64},'{64,0,64},'{23,0,23},
        '{7,0,7},
        '{64,20,34},'{64,2,21},'{23,1,7},'{9,0,5},'{64,7,0},'{39,14,0},'{31,21,0},'{16,26,0},
        '{0,15,0},'{0,22,13},'{0,21,32},'{0,0,64},'{0,18,20},'{7,0,53},'{32,32,32},'{9,9,9},
        '{64,3,0},'{47,64,0},'{43,60,0},'{22,64,0},'{0,35,0},'{0,64,31},'{0,42,64},'{0,7,64},
        '{14,0,64},'{30,0,64},'{46,6,32},'{17,9,0},'{64,19,0},'{33,57,0},'{26,64,0},'{0,64,0},
        '{0,64,0},'{18,64,25},'{0,64,51},'{21,34,64},'{10,20,51},'{33,31,60},'{53,4,64},
        '{64,2,23},
        '{64,32,0},'{47,45,0},'{35,64,0},'{33,24,0},'{14,11,0},'{4,20,2},'{0,21,14},'{5,5,11},
        '{5,8,23},'{27,16,6},'{44,2,0},'{64,21,14},'{56,27,0},'{64,64,0},'{39,57,0},'{24,46,0},
        '{7,7,13},'{56,64,21},'{30,64,47},'{38,38,64},'{35,25,64},'{17,17,17},'{30,30,30},
        '{56,64,64},
        '{42,2,0},'{14,0,0},'{0,53,0},'{0,17,0},'{47,45,0},'{16,13,0},'{46,24,0},'{19,6,0}
    };

    typedef struct packed {
        result_kind_t kind;
        logic [3:0]   x;
        logic [2:0]   y;
        logic [6:0]   red;
        logic [6:0]   green;
        logic [6:0]   blue;
        logic [3:0]   lighting;
        logic [7:0]   reply;
        logic         last;
    } led_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] header = 8'd0;
    logic [7:0] byte0 = 8'd0;
    logic [7:0] byte1 = 8'd0;
    logic [7:0] byte2 = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       result_kind;
    logic [3:0] led_x;
    logic [2:0] led_y;
    logic [6:0] red;
    logic [6:0] green;
    logic [6:0] blue;
    logic [3:0] lighting;
    logic [7:0] response_byte;
    logic       last;

    // Decoder state mirrored by the predictor.
    logic [2:0] grid_layout = LAYOUT_DEFAULT;
    logic [6:0] sx_count = 7'd0;
    logic [7:0] sx_head [8];

    led_result_t pending_results [$];
    logic [7:0]  sx_bytes [$];

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int hold_cycles = 0;
    int packets_sent = 0;
    int leds_seen = 0;
    int replies_seen = 0;
    int mismatches = 0;
    int cycles = 0;

    usb_midi_packet_to_led_commands_unit #(
        .SYSEX_MAX(SYSEX_MAX),
        .LAYOUT_MAX(LAYOUT_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .header(header),
        .byte0(byte0),
        .byte1(byte1),
        .byte2(byte2),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_kind(result_kind),
        .led_x(led_x),
        .led_y(led_y),
        .red(red),
        .green(green),
        .blue(blue),
        .lighting(lighting),
        .response_byte(response_byte),
        .last(last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void push_led(input logic [3:0] x, input logic [2:0] y,
                                     input logic [6:0] color, input logic [3:0] light);
        led_result_t r;
        r = '0;
        r.kind = RES_LED;
        r.x = x;
        r.y = y;
        r.red = color_lut[color][0];
        r.green = color_lut[color][1];
        r.blue = color_lut[color][2];
        r.lighting = light;
        r.last = 1'b1;
        pending_results.push_back(r);
    endfunction

    function automatic void decode_note(input logic [3:0] chan, input logic [7:0] note,
                                        input logic [7:0] vel);
        int n;
        int x;
        int y;
        bit hit;
        n = note;
        x = 0;
        y = 0;
        hit = 1'b0;
        if (grid_layout == LAYOUT_DRUM)
        begin
            if (n >= 36 && n <= 67)
            begin
                x = n % 4;
                y = (n - 36) / 4;
                hit = 1'b1;
            end
            else if (n >= 68 && n <= 99)
            begin
                x = n % 4 + 4;
                y = (n - 68) / 4;
                hit = 1'b1;
            end
            else if (n >= 100 && n <= 107)
            begin
                x = 8;
                y = 107 - n;
                hit = 1'b1;
            end
        end
        else if (n >= 11 && n <= 89 && n % 10 != 0)
        begin
            x = n % 10 - 1;
            y = n / 10 - 1;
            hit = 1'b1;
        end
        if (hit && vel < 8'd128)
            push_led(4'(x), 3'(y), vel[6:0], (chan <= 4'd2) ? chan : 4'd0);
    endfunction

    function automatic void decode_control(input logic [3:0] chan, input logic [7:0] ctl,
                                           input logic [7:0] val);
        int row;
        if (val >= 8'd128)
            return;
        for (row = 0; row < 8; row++)
        begin
            if (ctrl_rows[row] == ctl)
            begin
                push_led(4'd9, 3'(row), val[6:0], chan);
                return;
            end
        end
    endfunction

    function automatic void take_sysex_byte(input logic [7:0] b);
        if (sx_count < 7'd8)
            sx_head[sx_count[2:0]] = b;
        sx_count = sx_count + 7'd1;
    endfunction

    function automatic void decode_sysex(input logic [3:0] cin, input logic [7:0] d0,
                                         input logic [7:0] d1, input logic [7:0] d2);
        int n;
        int k;
        bit id_ok;
        led_result_t r;
        // A message that would run past the buffer is thrown away whole.
        if (sx_count >= SYSEX_MAX - 3)
        begin
            sx_count = 7'd0;
            return;
        end
        take_sysex_byte(d0);
        if (cin == CIN_SX_CONT || cin == CIN_SX_END3 || cin == CIN_SX_END2)
            take_sysex_byte(d1);
        if (cin == CIN_SX_CONT || cin == CIN_SX_END3)
            take_sysex_byte(d2);
        if (cin == CIN_SX_CONT)
            return;
        n = sx_count;
        sx_count = 7'd0;
        id_ok = 1'b1;
        for (k = 0; k < 6; k++)
            if (sx_head[k] != maker_id[k])
                id_ok = 1'b0;
        if (n < SX_MIN_LEN || !id_ok)
            return;
        if (sx_head[6] == SX_SET_LAYOUT)
        begin
            if (sx_head[7] <= LAYOUT_MAX)
                grid_layout = sx_head[7][2:0];
        end
        else if (sx_head[6] == SX_CHALLENGE)
        begin
            for (k = 0; k < 10; k++)
            begin
                r = '0;
                r.kind = RES_RESPONSE;
                r.reply = reply_lut[k];
                r.last = (k == 9);
                pending_results.push_back(r);
            end
        end
    endfunction

    function automatic void decode_packet(input logic [7:0] h, input logic [7:0] d0,
                                          input logic [7:0] d1, input logic [7:0] d2);
        case (h[3:0])
            CIN_NOTE_ON:  decode_note(d0[3:0], d1, d2);
            CIN_NOTE_OFF: decode_note(d0[3:0], d1, 8'd0);
            CIN_CTRL:     decode_control(d0[3:0], d1, d2);
            CIN_SX_CONT, CIN_SX_END1, CIN_SX_END2, CIN_SX_END3:
                decode_sysex(h[3:0], d0, d1, d2);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------------
    // The cable number in the high nibble is random; the decoder ignores it.
    function automatic logic [7:0] hdr(input logic [3:0] cin);
        return {4'($urandom_range(0, 15)), cin};
    endfunction

    task automatic send_packet(input logic [7:0] h, input logic [7:0] d0,
                               input logic [7:0] d1, input logic [7:0] d2);
        int gap;
        gap = send_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        header <= h;
        byte0 <= d0;
        byte1 <= d1;
        byte2 <= d2;
        do @(posedge clk); while (in_ready !== 1'b1);
        decode_packet(h, d0, d1, d2);
        packets_sent++;
    endtask

    task automatic load_maker_id();
        sx_bytes.delete();
        foreach (maker_id[i])
            sx_bytes.push_back(maker_id[i]);
    endtask

    // Splits the gathered message into continuation packets and one end packet.
    task automatic send_sysex_msg();
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        while (sx_bytes.size() > 3)
        begin
            a = sx_bytes.pop_front();
            b = sx_bytes.pop_front();
            c = sx_bytes.pop_front();
            send_packet(hdr(CIN_SX_CONT), a, b, c);
        end
        a = 8'($urandom);
        b = 8'($urandom);
        c = 8'($urandom);
        case (sx_bytes.size())
            1: send_packet(hdr(CIN_SX_END1), sx_bytes[0], b, c);
            2: send_packet(hdr(CIN_SX_END2), sx_bytes[0], sx_bytes[1], c);
            3: send_packet(hdr(CIN_SX_END3), sx_bytes[0], sx_bytes[1], sx_bytes[2]);
            default: ;
        endcase
        sx_bytes.delete();
    endtask

    task automatic send_layout(input logic [7:0] idx);
        load_maker_id();
        sx_bytes.push_back(SX_SET_LAYOUT);
        sx_bytes.push_back(idx);
        sx_bytes.push_back(SX_END);
        send_sysex_msg();
    endtask

    // A challenge message of the given total length, end marker included.
    task automatic send_challenge(input int total);
        load_maker_id();
        sx_bytes.push_back(SX_CHALLENGE);
        while (sx_bytes.size() < total - 1)
            sx_bytes.push_back(8'($urandom_range(0, 127)));
        sx_bytes.push_back(SX_END);
        send_sysex_msg();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus a long hold-off when one is requested.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else
            begin
                stall = recv_idle ? $urandom_range(0, 3) : 0;
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1 && hold_cycles == 0);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        led_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d x %0d y %0d byte %h",
                       result_kind, led_x, led_y, response_byte);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", 8'(want.kind), 8'(result_kind));
                check_field("led_x", 8'(want.x), 8'(led_x));
                check_field("led_y", 8'(want.y), 8'(led_y));
                check_field("red", 8'(want.red), 8'(red));
                check_field("green", 8'(want.green), 8'(green));
                check_field("blue", 8'(want.blue), 8'(blue));
                check_field("lighting", 8'(want.lighting), 8'(lighting));
                check_field("response_byte", want.reply, response_byte);
                check_field("last", 8'(want.last), 8'(last));
                if (want.kind == RES_LED)
                    leds_seen++;
                else
                    replies_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_session_notes();
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd11, 8'd0);
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd2}, 8'd89, 8'd127);
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd1}, 8'd19, 8'd5);
        // Channels above two fall back to plain light.
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd15}, 8'd81, 8'd64);
        send_packet(hdr(CIN_NOTE_OFF), {CIN_NOTE_OFF, 4'd1}, 8'd55, 8'd99);
        // Notes ending in zero and notes outside the grid light nothing.
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd10, 8'd3);
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd20, 8'd3);
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd90, 8'd3);
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd0, 8'd3);
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd255, 8'd3);
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd45, 8'd128);
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd45, 8'd255);
        wait_idle();
    endtask

    task automatic test_control_column();
        int row;
        for (row = 0; row < 8; row++)
            send_packet(hdr(CIN_CTRL), {CIN_CTRL, 4'($urandom_range(0, 15))}, ctrl_rows[row],
                        (row % 2 == 0) ? 8'd0 : 8'd127);
        send_packet(hdr(CIN_CTRL), {CIN_CTRL, 4'd15}, 8'd104, 8'd77);
        send_packet(hdr(CIN_CTRL), {CIN_CTRL, 4'd0}, 8'd103, 8'd5);
        send_packet(hdr(CIN_CTRL), {CIN_CTRL, 4'd0}, 8'd112, 8'd5);
        send_packet(hdr(CIN_CTRL), {CIN_CTRL, 4'd0}, 8'd105, 8'd128);
        wait_idle();
    endtask

    task automatic test_every_cin();
        int c;
        for (c = 0; c < 16; c++)
            send_packet(hdr(4'(c)), 8'($urandom), 8'($urandom), 8'($urandom));
        wait_idle();
    endtask

    task automatic test_layouts();
        int drum_notes [8] = '{35, 36, 67, 68, 99, 100, 107, 108};
        send_layout({5'd0, LAYOUT_DRUM});
        foreach (drum_notes[i])
            send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'(i)}, 8'(drum_notes[i]),
                        8'($urandom_range(0, 127)));
        // An index above the limit leaves the drum map in place.
        send_layout(8'd7);
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd36, 8'd21);
        send_layout(8'(LAYOUT_MAX));
        send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'd0}, 8'd36, 8'd21);
        send_layout({5'd0, LAYOUT_DEFAULT});
        wait_idle();
    endtask

    task automatic test_sysex_messages();
        send_challenge(8);
        send_challenge(9);
        // Too short, foreign header, unknown message type.
        load_maker_id();
        sx_bytes.push_back(SX_CHALLENGE);
        send_sysex_msg();
        load_maker_id();
        sx_bytes[3] = 8'h2A;
        sx_bytes.push_back(SX_CHALLENGE);
        sx_bytes.push_back(SX_END);
        send_sysex_msg();
        load_maker_id();
        sx_bytes.push_back(8'h41);
        sx_bytes.push_back(SX_END);
        send_sysex_msg();
        // A message that runs past the limit is dropped; the next one still works.
        send_challenge(SYSEX_MAX);
        send_challenge(9);
        wait_idle();
    endtask

    task automatic test_backpressure();
        int i;
        send_idle = 1'b0;
        hold_cycles = 80;
        for (i = 0; i < 8; i++)
            send_packet(hdr(CIN_NOTE_ON), {CIN_NOTE_ON, 4'($urandom_range(0, 3))},
                        8'(10 * $urandom_range(1, 8) + $urandom_range(1, 9)),
                        8'($urandom_range(0, 127)));
        send_challenge(9);
        send_packet(hdr(CIN_CTRL), {CIN_CTRL, 4'd3}, 8'd108, 8'd9);
        wait_idle();
        send_idle = 1'b1;
    endtask

    task automatic send_random_sysex();
        int n;
        int pick;
        load_maker_id();
        if ($urandom_range(0, 6) == 0)
            sx_bytes[$urandom_range(0, 5)] = 8'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            sx_bytes.push_back(SX_SET_LAYOUT);
            if ($urandom_range(0, 4) == 0)
                sx_bytes.push_back(8'($urandom));
            else if ($urandom_range(0, 1) == 0)
                sx_bytes.push_back({5'd0, LAYOUT_DRUM});
            else
                sx_bytes.push_back(8'($urandom_range(0, 7)));
        end
        else if (pick < 8)
            sx_bytes.push_back(SX_CHALLENGE);
        else
            sx_bytes.push_back(8'($urandom));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 62) : $urandom_range(0, 3);
        repeat (n) sx_bytes.push_back(8'($urandom_range(0, 127)));
        sx_bytes.push_back(SX_END);
        if ($urandom_range(0, 9) == 0)
            sx_bytes = sx_bytes[0:$urandom_range(0, 6)];
        send_sysex_msg();
    endtask

    task automatic test_random_traffic();
        int start;
        int pick;
        logic [3:0] cin;
        logic [7:0] a;
        logic [7:0] b;
        start = packets_sent;
        while (packets_sent - start < RANDOM_PACKETS)
        begin
            // Alternate stretches with and without idle cycles on both sides.
            send_idle = ((packets_sent - start) / 6) % 2 == 0;
            recv_idle = send_idle;
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                cin = ($urandom_range(0, 3) == 0) ? CIN_NOTE_OFF : CIN_NOTE_ON;
                a = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 110));
                b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                                : 8'($urandom_range(0, 127));
                send_packet(hdr(cin), {cin, 4'($urandom_range(0, 15))}, a, b);
            end
            else if (pick < 55)
            begin
                a = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(104, 111));
                b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                                : 8'($urandom_range(0, 127));
                send_packet(hdr(CIN_CTRL), {CIN_CTRL, 4'($urandom_range(0, 15))}, a, b);
            end
            else if (pick < 80)
                send_random_sysex();
            else if (pick < 90)
                send_packet(hdr(4'($urandom_range(CIN_SX_CONT, CIN_SX_END3))),
                            8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_packet(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
        wait_idle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_session_notes();
        test_control_column();
        test_every_cin();
        test_layouts();
        test_sysex_messages();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge clk);
        $display("%0d packets: both note maps, control column, all code indexes,", packets_sent);
        $display("layout and challenge sysex with drops; %0d LED writes, %0d reply bytes.",
                 leds_seen, replies_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
